// ----- rtl/core/led_step_sequencer_top_defines.svh -----
// ----------------------------------------------------------------------------
// LED step sequencer assertion macros
// Shared property wrappers for the sequencer RTL, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LED_STEP_SEQUENCER_TOP_DEFINES_SVH
`define LED_STEP_SEQUENCER_TOP_DEFINES_SVH

// Implication or plain property that must hold at every clock edge out of reset.
`define LSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define LSS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// LED step sequencer package
// Operation codes, field widths and the packed transaction layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

	localparam int LSS_MAX_STEPS = 16;
	localparam int DUR_W = 24;
	localparam int BRI_W = 8;
	localparam int IN_DATA_W = 120;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [2:0] {
		OP_TICK        = 3'd0,
		OP_WRITE_STEP  = 3'd1,
		OP_START_SEQ   = 3'd2,
		OP_START_BLINK = 3'd3,
		OP_STOP        = 3'd4
	} op_t;

	// Input transaction, last field in the lowest bits.
	typedef struct packed {
		logic             pad;
		logic [DUR_W-1:0] off_duration;
		logic [BRI_W-1:0] off_brightness;
		logic [DUR_W-1:0] on_duration;
		logic [BRI_W-1:0] on_brightness;
		logic [7:0]       blink_count;
		logic [7:0]       seq_length;
		logic [BRI_W-1:0] step_brightness;
		logic [DUR_W-1:0] step_duration;
		logic [3:0]       step_index;
		op_t              op;
	} item_t;

	// Result transaction, last field in the lowest bits.
	typedef struct packed {
		logic [5:0]       pad;
		logic             animation_end;
		logic             active;
		logic [BRI_W-1:0] brightness;
	} res_t;

endpackage

`default_nettype wire

// ----- rtl/core/led_step_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// LED step sequencer top level
// Plays a table of (duration, brightness) steps or a blink pattern, one
// result transaction per input transaction.
// ----------------------------------------------------------------------------
// Path: each input transaction is taken into the input register, then moves
//   on into the result register that drives m_tvalid and m_tdata.
// Throughput: one transaction per cycle; s_tready stays high while the input
//   register is empty or moving on, and drops only when both registers are full
//   and the result waits for m_tready.
// Reset: arst_n clears playback state, loop_enable and both valid flags at
//   once; the step table is not cleared and holds nothing until written.
`default_nettype none

`include "led_step_sequencer_top_defines.svh"

module led_step_sequencer_top #(
	parameter int MAX_STEPS = lss_pkg::LSS_MAX_STEPS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration: bit 0 is loop_enable.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_data,
	// Input stream.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// From bit 0: op[3], step_index[4], step_duration[24], step_brightness[8],
	// seq_length[8], blink_count[8], on_brightness[8], on_duration[24],
	// off_brightness[8], off_duration[24], one zero pad bit.
	input  wire logic [lss_pkg::IN_DATA_W-1:0] s_tdata,
	// Result stream.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// From bit 0: brightness[8], active[1], animation_end[1], six zero pad bits.
	output logic [lss_pkg::OUT_DATA_W-1:0]     m_tdata
);

	// Step counters and lengths must reach MAX_STEPS itself; table indexes
	// only need to address the entries.
	localparam int LEN_W = $clog2(MAX_STEPS + 1);
	localparam int IDX_W = $clog2(MAX_STEPS);
	localparam int HALF  = MAX_STEPS / 2;

	// Input register stage.
	lss_pkg::item_t item_s1;
	logic           valid_s1;

	// Result register stage.
	lss_pkg::res_t  res_s2;
	logic           valid_s2;

	// Playback state.
	logic                      loop_enable_q;
	logic [LEN_W-1:0]          cur_step_q;
	logic [LEN_W-1:0]          act_len_q;
	logic [lss_pkg::DUR_W-1:0] elapsed_q;
	logic                      playing_q;
	logic [lss_pkg::BRI_W-1:0] last_bri_q;

	// Step table, held in flops so a blink pattern fills all its pairs together.
	logic [lss_pkg::DUR_W-1:0] dur_q [MAX_STEPS];
	logic [lss_pkg::BRI_W-1:0] bri_q [MAX_STEPS];

	// Next-state values.
	logic                      advance;
	logic                      process;
	logic [LEN_W-1:0]          cur_step_d;
	logic [LEN_W-1:0]          act_len_d;
	logic [lss_pkg::DUR_W-1:0] elapsed_d;
	logic                      playing_d;
	logic [lss_pkg::BRI_W-1:0] last_bri_d;
	logic                      end_d;
	logic [lss_pkg::DUR_W-1:0] el_inc;
	logic [lss_pkg::DUR_W-1:0] rd_dur;
	logic [lss_pkg::BRI_W-1:0] rd_bri;
	logic [LEN_W-1:0]          nxt_step;
	logic                      play_tick;
	logic [8:0]                blink_len;
	logic [8:0]                seq_len;

	// The result register moves whenever it is empty or being drained, and
	// the input register refills whenever its transaction moves on.
	assign advance   = !valid_s2 || m_tready;
	assign process   = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = res_s2;

	// Table read at the current step; the guard on cur_step_q below uses
	// the read only inside the active length of the table.
	assign rd_dur = dur_q[cur_step_q[IDX_W-1:0]];
	assign rd_bri = bri_q[cur_step_q[IDX_W-1:0]];

	assign el_inc    = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign nxt_step  = cur_step_q + 1'b1;
	assign seq_len   = {1'b0, item_s1.seq_length};
	assign blink_len = {item_s1.blink_count, 1'b0};

	always_comb begin
		cur_step_d = cur_step_q;
		act_len_d  = act_len_q;
		elapsed_d  = elapsed_q;
		playing_d  = playing_q;
		last_bri_d = last_bri_q;
		end_d      = 1'b0;
		play_tick  = playing_q || loop_enable_q;
		unique case (item_s1.op)
			lss_pkg::OP_TICK: begin
				// With loop_enable set, a tick sets playing again; the step pointer is not reset.
				playing_d = play_tick;
				if (play_tick && (cur_step_q < act_len_q)) begin
					last_bri_d = rd_bri;
					elapsed_d  = el_inc;
					if (el_inc >= rd_dur) begin
						elapsed_d  = '0;
						cur_step_d = nxt_step;
						if (nxt_step >= act_len_q) begin
							if (loop_enable_q) begin
								cur_step_d = '0;
							end else begin
								last_bri_d = '0;
								playing_d  = 1'b0;
								end_d      = 1'b1;
							end
						end
					end
				end
			end
			lss_pkg::OP_START_SEQ: begin
				act_len_d  = (seq_len > 9'(MAX_STEPS)) ? LEN_W'(MAX_STEPS) : LEN_W'(seq_len);
				cur_step_d = '0;
				elapsed_d  = '0;
				playing_d  = 1'b1;
			end
			lss_pkg::OP_START_BLINK: begin
				act_len_d  = (blink_len > 9'(MAX_STEPS)) ? LEN_W'(MAX_STEPS)
				                                         : LEN_W'(blink_len);
				cur_step_d = '0;
				elapsed_d  = '0;
				playing_d  = 1'b1;
			end
			lss_pkg::OP_STOP: begin
				// A stop always flags the end, playing or not.
				playing_d = 1'b0;
				end_d     = 1'b1;
			end
			default: begin
				// Step writes touch only the table; unused codes do nothing.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			loop_enable_q <= 1'b0;
			cur_step_q    <= '0;
			act_len_q     <= '0;
			elapsed_q     <= '0;
			playing_q     <= 1'b0;
			last_bri_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				loop_enable_q <= cfg_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (process) begin
				cur_step_q <= cur_step_d;
				act_len_q  <= act_len_d;
				elapsed_q  <= elapsed_d;
				playing_q  <= playing_d;
				last_bri_q <= last_bri_d;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= lss_pkg::item_t'(s_tdata);
		end
		if (process) begin
			res_s2.pad           <= '0;
			res_s2.brightness    <= last_bri_d;
			res_s2.active        <= playing_d;
			res_s2.animation_end <= end_d;
		end
	end

	// Step table writes: one entry for a step write, pairs for a blink fill.
	// A step index at or past MAX_STEPS matches no entry and is dropped.
	always_ff @(posedge clk) begin
		if (process) begin
			for (int i = 0; i < MAX_STEPS; i++) begin
				if ((item_s1.op == lss_pkg::OP_WRITE_STEP) &&
				    (8'(item_s1.step_index) == 8'(i))) begin
					dur_q[i] <= item_s1.step_duration;
					bri_q[i] <= item_s1.step_brightness;
				end
			end
			for (int i = 0; i < HALF; i++) begin
				if ((item_s1.op == lss_pkg::OP_START_BLINK) &&
				    (item_s1.blink_count > 8'(i))) begin
					dur_q[2*i]   <= item_s1.on_duration;
					bri_q[2*i]   <= item_s1.on_brightness;
					dur_q[2*i+1] <= item_s1.off_duration;
					bri_q[2*i+1] <= item_s1.off_brightness;
				end
			end
		end
	end

	// The sequence length never exceeds the table.
	`LSS_ASSERT(a_len_bound, act_len_q <= LEN_W'(MAX_STEPS), "active length beyond table")
	// The step pointer only moves while below the length; a start zeroes it and reloads the length.
	`LSS_ASSERT(a_step_bound, cur_step_q <= act_len_q, "current step past active length")
	// An ending result never reports playback as active.
	`LSS_ASSERT_NEVER(a_end_inactive, valid_s2 && res_s2.animation_end && res_s2.active,
		"animation_end reported with active set")
	// A result that ended playback naturally drives the LEDs dark.
	`LSS_ASSERT(a_end_dark,
		process && end_d && (item_s1.op == lss_pkg::OP_TICK) |-> (last_bri_d == '0),
		"natural end did not drive zero brightness")
	// A stalled result register keeps the state frozen.
	`LSS_ASSERT(a_stall_hold, valid_s2 && !m_tready |=> $stable(cur_step_q) && $stable(playing_q),
		"playback state moved while the result was stalled")

endmodule

`default_nettype wire

// ----- sim/led_step_sequencer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED step sequencer checker
// Watches the configuration, input and result channels of the sequencer,
// predicts every result transaction from its own copy of the playback state
// and compares each one field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module led_step_sequencer_checker #(
	parameter int MAX_STEPS = lss_pkg::LSS_MAX_STEPS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic                              cfg_data,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [lss_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [lss_pkg::OUT_DATA_W-1:0]    m_tdata,
	output int                                errors,
	output int                                pending,
	output int                                checked
);
	import lss_pkg::*;

	localparam int STEP_W = $clog2(MAX_STEPS + 1);

	logic [DUR_W-1:0]  dur_tbl [MAX_STEPS];
	logic [BRI_W-1:0]  bri_tbl [MAX_STEPS];
	logic [STEP_W-1:0] cur_step;
	logic [STEP_W-1:0] play_len;
	logic [DUR_W-1:0]  elapsed;
	logic [BRI_W-1:0]  level;
	bit                playing;
	bit                loop_en;
	res_t              expected_results [$];
	int                err_n;
	int                chk_n;

	function automatic void start_play(input int unsigned n);
		play_len = (n > MAX_STEPS) ? STEP_W'(MAX_STEPS) : STEP_W'(n);
		cur_step = '0;
		elapsed  = '0;
		playing  = 1'b1;
	endfunction

	// Advances the sequencer state by one transaction and returns its result.
	function automatic res_t play_item(input item_t it);
		res_t        r;
		bit          ended;
		int unsigned pairs;
		int          i;
		r     = '0;
		ended = 1'b0;
		case (it.op)
			OP_TICK: begin
				if (loop_en && !playing)
					playing = 1'b1;
				if (playing && cur_step < play_len) begin
					level = bri_tbl[cur_step];
					if (elapsed != '1)
						elapsed = elapsed + 1'b1;
					if (elapsed >= dur_tbl[cur_step]) begin
						elapsed  = '0;
						cur_step = cur_step + 1'b1;
						if (cur_step >= play_len) begin
							if (loop_en) begin
								cur_step = '0;
							end else begin
								level   = '0;
								playing = 1'b0;
								ended   = 1'b1;
							end
						end
					end
				end
			end
			OP_WRITE_STEP: begin
				if (it.step_index < MAX_STEPS) begin
					dur_tbl[it.step_index] = it.step_duration;
					bri_tbl[it.step_index] = it.step_brightness;
				end
			end
			OP_START_SEQ: start_play(it.seq_length);
			OP_START_BLINK: begin
				pairs = it.blink_count;
				for (i = 0; i < pairs && i < MAX_STEPS / 2; i++) begin
					dur_tbl[2 * i]     = it.on_duration;
					bri_tbl[2 * i]     = it.on_brightness;
					dur_tbl[2 * i + 1] = it.off_duration;
					bri_tbl[2 * i + 1] = it.off_brightness;
				end
				start_play(2 * pairs);
			end
			OP_STOP: begin
				playing = 1'b0;
				ended   = 1'b1;
			end
			default: ;
		endcase
		r.brightness    = level;
		r.active        = playing;
		r.animation_end = ended;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			for (int k = 0; k < MAX_STEPS; k++) begin
				dur_tbl[k] = '0;
				bri_tbl[k] = '0;
			end
			cur_step = '0;
			play_len = '0;
			elapsed  = '0;
			level    = '0;
			playing  = 1'b0;
			loop_en  = 1'b0;
			expected_results.delete();
			err_n    = 0;
			chk_n    = 0;
			errors  <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// A result never leaves in the cycle its input is taken, so compare first.
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$error("result transaction with no prediction waiting: %h", m_tdata);
					err_n++;
				end else begin
					want = expected_results.pop_front();
					chk_n++;
					if (got.brightness !== want.brightness) begin
						$error("brightness: expected %0d, actual %0d",
							want.brightness, got.brightness);
						err_n++;
					end
					if (got.active !== want.active) begin
						$error("active: expected %0d, actual %0d", want.active, got.active);
						err_n++;
					end
					if (got.animation_end !== want.animation_end) begin
						$error("animation_end: expected %0d, actual %0d",
							want.animation_end, got.animation_end);
						err_n++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				loop_en = cfg_data;
			if (s_tvalid && s_tready)
				expected_results.push_back(play_item(item_t'(s_tdata)));
			errors  <= err_n;
			pending <= expected_results.size();
			checked <= chk_n;
		end
	end

endmodule

// ----- sim/led_step_sequencer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED step sequencer testbench
// Drives directed and random step, blink and tick transactions into the
// sequencer under both loop settings, with random idling on both streams and
// a long result back-pressure hold. A separate checker predicts and compares
// every result; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module led_step_sequencer_top_tb;
	import lss_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 3;
	localparam int IDLE_PCT        = 7;
	localparam int RX_HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int RANDOM_PHASES   = 4;
	localparam int SETTLE_CYCLES   = 8;

	// Op codes the block has no meaning for; it must answer them like a write.
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_data  = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tready  = 1'b0;
	logic                  cfg_ready;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [OUT_DATA_W-1:0] m_tdata;

	int          fail_count;
	int          pending;
	int          checked;
	int unsigned cycles = 0;

	// When quiet is set neither stream idles; rx_hold_req asks the receiver
	// for one long back-pressure hold.
	bit quiet        = 1'b0;
	bit rx_hold_req  = 1'b0;
	bit rx_hold_done = 1'b0;

	int n_sent;
	int n_ticks;
	int n_writes;
	int n_starts;
	int n_stops;
	int n_reserved;

	led_step_sequencer_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	led_step_sequencer_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (fail_count),
		.pending  (pending),
		.checked  (checked)
	);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[led_step_sequencer_top] ERROR");
			$finish;
		end
	end

	// Result receiver. It drops m_tready at random, about IDLE_PCT percent of the
	// time, never while quiet is set, and once holds it low through a back-pressure
	// hold so that the block backs up and has to stall the input stream.
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req && !rx_hold_done) begin
				rx_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Every field starts out random, so bits that the op does not use still
	// toggle; callers overwrite the fields that matter.
	function automatic item_t make_item(input logic [2:0] code);
		logic [127:0] raw;
		item_t        it;
		raw     = {$urandom(), $urandom(), $urandom(), $urandom()};
		it      = raw[IN_DATA_W-1:0];
		it.pad  = 1'b0;
		it.op   = op_t'(code);
		return it;
	endfunction

	// Mostly short steps so sequences actually advance, with an occasional
	// long or full-range one.
	function automatic logic [DUR_W-1:0] pick_duration();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 85)
			return DUR_W'($urandom_range(4));
		else if (roll < 95)
			return DUR_W'($urandom_range(40, 5));
		return DUR_W'($urandom());
	endfunction

	function automatic logic [7:0] pick_length();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return 8'($urandom_range(LSS_MAX_STEPS, 1));
		else if (roll < 90)
			return '0;
		return 8'($urandom_range(255, LSS_MAX_STEPS + 1));
	endfunction

	function automatic logic [7:0] pick_pairs();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return 8'($urandom_range(4, 1));
		else if (roll < 90)
			return '0;
		return 8'($urandom_range(255, 5));
	endfunction

	// Offers one transaction and returns at the edge that accepts it, with
	// s_tvalid still high so the next call can follow without a gap.
	task automatic send(input item_t it);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= it;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (it.op)
			OP_TICK:        n_ticks++;
			OP_WRITE_STEP:  n_writes++;
			OP_START_SEQ,
			OP_START_BLINK: n_starts++;
			OP_STOP:        n_stops++;
			default:        n_reserved++;
		endcase
		if (it.op <= OP_STOP)
			n_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// The register may only change while the block has nothing in flight.
	task automatic write_loop(input bit value);
		wait_for_results();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic tick_run(input int n);
		repeat (n) begin
			if ($urandom_range(99) < 2)
				send(make_item(OP_STOP));
			else
				send(make_item(OP_TICK));
		end
	endtask

	task automatic directed_part();
		item_t it;
		// Idle block: a tick holds the last level, a stop still flags the end.
		send(make_item(OP_TICK));
		send(make_item(OP_STOP));
		// A zero-length start plays nothing but stays active.
		it = make_item(OP_START_SEQ);
		it.seq_length = '0;
		send(it);
		send(make_item(OP_TICK));
		send(make_item(OP_STOP));
		// The widest blink fills the whole table, so nothing is unwritten
		// from here on. Durations of one and zero both last one tick.
		it = make_item(OP_START_BLINK);
		it.blink_count    = '1;
		it.on_brightness  = '1;
		it.on_duration    = DUR_W'(1);
		it.off_brightness = '0;
		it.off_duration   = '0;
		send(it);
		tick_run(2);
		it = make_item(OP_WRITE_STEP);
		it.step_index      = '1;
		it.step_duration   = '1;
		it.step_brightness = 8'hA5;
		send(it);
		it = make_item(OP_WRITE_STEP);
		it.step_index      = '0;
		it.step_duration   = DUR_W'(2);
		it.step_brightness = 8'h5A;
		send(it);
		// An oversized length is clamped to the table size.
		it = make_item(OP_START_SEQ);
		it.seq_length = '1;
		send(it);
		tick_run(3);
		// A one-step sequence runs to its natural end with loop off.
		it = make_item(OP_START_SEQ);
		it.seq_length = 8'd1;
		send(it);
		tick_run(2);
		send(make_item(OP_RSVD_FIRST));
		send(make_item(OP_RSVD_LAST));
		// With loop on, a tick after the end reports active again without moving the step; the blink that follows wraps.
		write_loop(1'b1);
		tick_run(2);
		it = make_item(OP_START_BLINK);
		it.blink_count  = 8'd1;
		it.on_duration  = '0;
		it.off_duration = '0;
		send(it);
		tick_run(2);
		send(make_item(OP_STOP));
		send(make_item(OP_TICK));
	endtask

	task automatic run_scene();
		item_t       it;
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 4) begin
			it = make_item(OP_START_BLINK);
			it.blink_count  = pick_pairs();
			it.on_duration  = pick_duration();
			it.off_duration = pick_duration();
			send(it);
			tick_run($urandom_range(30, 4));
		end else if (pick < 7) begin
			repeat ($urandom_range(6, 1)) begin
				it = make_item(OP_WRITE_STEP);
				it.step_duration = pick_duration();
				send(it);
			end
			it = make_item(OP_START_SEQ);
			it.seq_length = pick_length();
			send(it);
			tick_run($urandom_range(30, 4));
		end else if (pick == 7) begin
			// Noise: any op code with fully random fields.
			repeat ($urandom_range(4, 1))
				send(make_item(3'($urandom())));
		end else if (pick == 8) begin
			send(make_item(OP_STOP));
			tick_run($urandom_range(5, 1));
		end else begin
			it = make_item(OP_START_SEQ);
			it.seq_length = pick_length();
			send(it);
			tick_run($urandom_range(12, 2));
		end
	endtask

	initial begin
		int p;
		int goal;
		n_sent     = 0;
		n_ticks    = 0;
		n_writes   = 0;
		n_starts   = 0;
		n_stops    = 0;
		n_reserved = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		// Random phases alternate the loop setting. The second one starts the
		// long receiver hold while the sender keeps offering; the third runs
		// its first half with no idling on either side.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			write_loop(p % 2 == 1);
			if (p == 1)
				rx_hold_req <= 1'b1;
			if (p == 2)
				quiet <= 1'b1;
			goal = n_sent + ITEMS_PER_PHASE;
			while (n_sent < goal) begin
				if (p == 2 && quiet && n_sent > goal - ITEMS_PER_PHASE / 2)
					quiet <= 1'b0;
				run_scene();
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d transactions: %0d ticks, %0d step writes, ",
			n_sent + n_reserved, n_ticks, n_writes,
			"%0d starts, %0d stops, %0d reserved codes.",
			n_starts, n_stops, n_reserved);
		$display("%0d results checked with loop on and off and a %0d-cycle result hold.",
			checked, RX_HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("[led_step_sequencer_top] OK");
		end else begin
			$display("[led_step_sequencer_top] ERROR");
		end
		$finish;
	end

endmodule
